[rtl/core/dcbp_pkg.sv]
// Shared types, constants and helper functions for the set-dueling cache bypass block.
// No dependencies; imported by every module in rtl/core except dcbp_ram.
package dcbp_pkg;

  localparam int NUM_CORES_DEF = 8;
  localparam int CNT_W         = 12;
  localparam int DUEL_W        = 15;
  localparam int PROD_W        = 2 * DUEL_W;
  localparam int OUTQ_DEPTH    = 4;

  localparam logic [CNT_W-1:0] WIN_FULL = 12'd2048;
  localparam logic [CNT_W-1:0] PROB_ONE = 12'd2048;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_OTHER = 2'd2,
    CMD_FILL  = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] window;
    logic [CNT_W-1:0] first;
    logic [CNT_W-1:0] second;
    logic [CNT_W-1:0] other;
    logic [CNT_W-1:0] prob;
  } mon_entry_t;

  localparam int MON_W = $bits(mon_entry_t);

  localparam mon_entry_t MON_RESET = '{window: '0, first: '0, second: '0, other: '0,
                                       prob: PROB_ONE};

  typedef struct packed {
    logic bypass;
    logic bypass_valid;
    logic mode;
  } res_t;

  // count one sampled access, then fold the window when it fills
  function automatic mon_entry_t mon_step(mon_entry_t e, logic upd, logic hit,
                                          logic [1:0] pos);
    mon_entry_t      r;
    logic [CNT_W+1:0] s;
    r = e;
    if (upd) begin
      if (hit) begin
        if (pos == 2'd1) r.first = r.first + 1'b1;
        else if (pos == 2'd2) r.second = r.second + 1'b1;
        else r.other = r.other + 1'b1;
      end
      r.window = r.window + 1'b1;
    end
    if (r.window == WIN_FULL) begin
      s = {2'b0, r.first} + {2'b0, r.second} + {2'b0, r.other};
      r.prob = (s > {2'b0, PROB_ONE}) ? PROB_ONE : s[CNT_W-1:0];
      r.window = r.window >> 1;
      r.first  = r.first >> 1;
      r.second = r.second >> 1;
      r.other  = r.other >> 1;
    end
    return r;
  endfunction

  // line index is a multiple of 30: even, and nibble sum divisible by 15
  function automatic logic sample_hit(logic [41:0] q);
    logic [43:0] p;
    logic [7:0]  s;
    logic [4:0]  t;
    p = {2'b0, q};
    s = '0;
    for (int i = 0; i < 11; i++) begin
      s = s + {4'b0, p[4*i +: 4]};
    end
    t = {1'b0, s[7:4]} + {1'b0, s[3:0]};
    return !q[0] && (t == 5'd0 || t == 5'd15 || t == 5'd30);
  endfunction

endpackage

[rtl/core/dueling_cache_bypass_policy.sv]
// Set-dueling DRAM cache bypass policy, top level.
// Requests pass registers v1 and v2 into the result queue; one transaction per cycle while
// req_ready is high. Throughput set by the monitor RAM read-modify-write (forwarded) and the
// two-stage duel multiply/compare; a 4-entry result queue absorbs response stalls.
// Reset (rst, synchronous): counters and mode cleared, monitor entries read as reset
// through per-core valid bits; no clearing pass. Depends on dcbp_pkg and submodules.
module dueling_cache_bypass_policy #(
  parameter int NUM_CORES = dcbp_pkg::NUM_CORES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  logic [1:0]  command,
  input  logic [2:0]  core,
  input  logic [47:0] phys_address,
  input  logic        cache_hit,
  input  logic        monitor_hit,
  input  logic [1:0]  monitor_position,
  input  logic [15:0] random,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output logic        bypass,
  output logic        bypass_valid,
  output logic        mode
);
  import dcbp_pkg::*;

  logic       go, slot0, slot2, sample, fill, mode_eff;
  cmd_t       cmd;
  logic       v1, dec1, s0_1, s2_1;
  logic       v2, dec2, s0_2, s2_2, fill2;
  logic [$clog2(OUTQ_DEPTH):0] qcount;
  res_t       res, qout;

  assign cmd       = cmd_t'(command);
  assign slot0     = phys_address[14:10] == 5'd0;
  assign slot2     = phys_address[14:10] == 5'd2;
  assign sample    = sample_hit(phys_address[47:6]);
  assign req_ready = (qcount + ($clog2(OUTQ_DEPTH)+1)'(v1) + ($clog2(OUTQ_DEPTH)+1)'(v2))
                     < ($clog2(OUTQ_DEPTH)+1)'(OUTQ_DEPTH);
  assign go        = req_valid && req_ready;

  dcbp_duel u_duel (
    .clk(clk), .rst(rst), .go(go), .command(cmd), .cache_hit(cache_hit),
    .slot0(slot0), .slot2(slot2), .mode_eff(mode_eff)
  );

  dcbp_monitor #(.NUM_CORES(NUM_CORES)) u_mon (
    .clk(clk), .rst(rst), .go(go), .command(cmd), .core(core), .sample(sample),
    .monitor_hit(monitor_hit), .monitor_position(monitor_position), .random(random),
    .fill(fill)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= go;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    dec1 <= cmd == CMD_WRITE || cmd == CMD_FILL;
    s0_1 <= slot0;
    s2_1 <= slot2;
    dec2 <= dec1;
    s0_2 <= s0_1;
    s2_2 <= s2_1;
    fill2 <= fill;
  end

  always_comb begin
    res.bypass_valid = dec2;
    res.bypass       = dec2 && !s2_2 && (s0_2 || mode_eff) && !fill2;
    res.mode         = mode_eff;
  end

  dcbp_outq u_outq (
    .clk(clk), .rst(rst), .push(v2), .din(res), .count(qcount),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .dout(qout)
  );

  assign bypass       = qout.bypass;
  assign bypass_valid = qout.bypass_valid;
  assign mode         = qout.mode;
endmodule

[rtl/core/dcbp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dcbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule

[rtl/core/dcbp_duel.sv]
// Dueling group counters, halving, and cross-multiplied miss-rate compare.
// Depends on dcbp_pkg.
module dcbp_duel (
  input  logic              clk,
  input  logic              rst,
  input  logic              go,
  input  dcbp_pkg::cmd_t    command,
  input  logic              cache_hit,
  input  logic              slot0,
  input  logic              slot2,
  output logic              mode_eff
);
  import dcbp_pkg::*;

  logic [DUEL_W-1:0] pb_total, pb_misses, bab_total, bab_misses;
  logic [DUEL_W-1:0] pt_n, pm_n, bt_n, bm_n;
  logic              acc, miss, trig;
  logic              trig1, zero1, trig2, zero2;
  logic [DUEL_W-1:0] pt1, pm1, bt1, bm1;
  logic [PROD_W-1:0] p_pm_bt, p_bm_pt, p_pt_bt;
  logic              fill_mode;
  logic signed [PROD_W:0]   diff;
  logic signed [PROD_W+4:0] lhs, rhs;

  always_comb begin
    acc  = command == CMD_READ || command == CMD_WRITE;
    miss = command == CMD_READ && !cache_hit;
    pt_n = pb_total  + DUEL_W'(acc && slot0);
    pm_n = pb_misses + DUEL_W'(miss && slot0);
    bt_n = bab_total + DUEL_W'(acc && slot2);
    bm_n = bab_misses + DUEL_W'(miss && slot2);
    trig = command != CMD_FILL && (pt_n[DUEL_W-1] || bt_n[DUEL_W-1]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pb_total <= '0;
      pb_misses <= '0;
      bab_total <= '0;
      bab_misses <= '0;
      trig1 <= 1'b0;
      trig2 <= 1'b0;
      fill_mode <= 1'b0;
    end else begin
      trig1 <= go && trig;
      trig2 <= trig1;
      fill_mode <= mode_eff;
      if (go && command != CMD_FILL) begin
        if (trig) begin
          pb_total <= pt_n >> 1;
          pb_misses <= pm_n >> 1;
          bab_total <= bt_n >> 1;
          bab_misses <= bm_n >> 1;
        end else begin
          pb_total <= pt_n;
          pb_misses <= pm_n;
          bab_total <= bt_n;
          bab_misses <= bm_n;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    pt1 <= pt_n;
    pm1 <= pm_n;
    bt1 <= bt_n;
    bm1 <= bm_n;
    zero1 <= pt_n == '0 || bt_n == '0;
    zero2 <= zero1;
    p_pm_bt <= pm1 * bt1;
    p_bm_pt <= bm1 * pt1;
    p_pt_bt <= pt1 * bt1;
  end

  always_comb begin
    diff = $signed({1'b0, p_pm_bt}) - $signed({1'b0, p_bm_pt});
    lhs  = {diff, 4'b0};
    rhs  = $signed({5'b0, p_pt_bt});
    if (trig2) mode_eff = zero2 ? 1'b0 : (lhs < rhs);
    else mode_eff = fill_mode;
  end
endmodule

[rtl/core/dcbp_monitor.sv]
// Per-core reuse monitor counters in two RAMs, read-modify-write with forwarding.
// Depends on dcbp_pkg and dcbp_ram.
module dcbp_monitor #(
  parameter int NUM_CORES = dcbp_pkg::NUM_CORES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           go,
  input  dcbp_pkg::cmd_t command,
  input  logic [2:0]     core,
  input  logic           sample,
  input  logic           monitor_hit,
  input  logic [1:0]     monitor_position,
  input  logic [15:0]    random,
  output logic           fill
);
  import dcbp_pkg::*;

  localparam int AW = NUM_CORES > 1 ? $clog2(NUM_CORES) : 1;

  logic [6:0]       core_ext;
  logic [AW-1:0]    addr0, addr1, fwd_addr;
  logic             ok0, v1, ok1, samp1, mhit1, fwd_v, we;
  cmd_t             cmd1;
  logic [1:0]       mpos1;
  logic [15:0]      rnd1;
  logic [NUM_CORES-1:0] vb;
  logic [MON_W-1:0] wram, rram;
  mon_entry_t       fwd_w, fwd_r, wcur, rcur, wnew, rnew;
  logic [CNT_W-1:0] prob;

  assign core_ext = {4'b0, core};
  assign addr0    = core_ext[AW-1:0];
  assign ok0      = core_ext < 7'(NUM_CORES);

  dcbp_ram #(.WIDTH(MON_W), .DEPTH(NUM_CORES)) u_wram (
    .clk(clk), .we(we), .waddr(addr1), .wdata(wnew), .re(go), .raddr(addr0), .rdata(wram)
  );
  dcbp_ram #(.WIDTH(MON_W), .DEPTH(NUM_CORES)) u_rram (
    .clk(clk), .we(we), .waddr(addr1), .wdata(rnew), .re(go), .raddr(addr0), .rdata(rram)
  );

  always_comb begin
    if (fwd_v && fwd_addr == addr1) begin
      wcur = fwd_w;
      rcur = fwd_r;
    end else if (vb[addr1]) begin
      wcur = mon_entry_t'(wram);
      rcur = mon_entry_t'(rram);
    end else begin
      wcur = MON_RESET;
      rcur = MON_RESET;
    end
    wnew = mon_step(wcur, samp1 && cmd1 == CMD_WRITE, mhit1, mpos1);
    rnew = mon_step(rcur, samp1 && cmd1 == CMD_READ, mhit1, mpos1);
    we   = v1 && ok1 && cmd1 != CMD_FILL;
    if (!ok1) prob = PROB_ONE;
    else if (cmd1 == CMD_WRITE) prob = wnew.prob;
    else prob = rnew.prob;
    fill = {1'b0, rnd1} < {prob, 5'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      fwd_v <= 1'b0;
      vb <= '0;
    end else begin
      v1 <= go;
      fwd_v <= we;
      if (we) vb[addr1] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    addr1 <= addr0;
    ok1 <= ok0;
    cmd1 <= command;
    samp1 <= sample;
    mhit1 <= monitor_hit;
    mpos1 <= monitor_position;
    rnd1 <= random;
    fwd_addr <= addr1;
    fwd_w <= wnew;
    fwd_r <= rnew;
  end
endmodule

[rtl/core/dcbp_outq.sv]
// Small result queue that decouples the pipeline from the response channel.
// Depends on dcbp_pkg.
module dcbp_outq (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  dcbp_pkg::res_t      din,
  output logic [$clog2(dcbp_pkg::OUTQ_DEPTH):0] count,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output dcbp_pkg::res_t      dout
);
  import dcbp_pkg::*;

  localparam int PW = $clog2(OUTQ_DEPTH);

  res_t          q [OUTQ_DEPTH];
  logic [PW-1:0] wptr, rptr;
  logic          pop;

  assign rsp_valid = count != '0;
  assign pop       = rsp_valid && rsp_ready;
  assign dout      = q[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop) rptr <= rptr + 1'b1;
      count <= count + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) q[wptr] <= din;
  end
endmodule
